// File: hw/rtl/modexp_pkg.sv
// Package with the sequencer states and register indexes of the modular exponentiation core.
`timescale 1ns / 1ps

package modexp_pkg;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRIVATE_EXP = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } modexp_state_e;

endpackage

// File: hw/rtl/modular_exponentiation_core.sv
// Modular exponentiation core: base to a configured exponent modulo a configured modulus.
`timescale 1ns / 1ps

// An item is taken when start_i is high and busy_o is low; its result appears on
// power_result_o for one cycle with done_o high and cannot be held off. The core
// first reduces the base modulo the modulus, one base bit per cycle, then runs
// left-to-right square-and-multiply over all WIDTH exponent bits. Every modular
// product goes through one bit-serial shift-and-add unit, one multiplier bit per
// cycle. With a modulus below two the result is zero. busy_o drops in the cycle
// after done_o, so the next item can be taken then. Configuration writes are
// always accepted and must only be issued while busy_o is low.
module modular_exponentiation_core
  import modexp_pkg::*;
#(
  parameter int unsigned WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [WIDTH-1:0]   base_value_i,
  // Result channel
  output logic               done_o,
  output logic [WIDTH-1:0]   power_result_o,
  // Configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WIDTH-1:0]   cfg_data_i
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);
  localparam int unsigned ExtW = WIDTH + 2;

  modexp_state_e state_q, state_d;

  logic [WIDTH-1:0] modulus_q, pub_exp_q, priv_exp_q;
  logic [WIDTH-1:0] acc_q;    // running power
  logic [WIDTH-1:0] base_q;   // base reduced modulo the modulus
  logic [WIDTH-1:0] prod_q;   // partial product of the serial multiplier
  logic [WIDTH-1:0] opb_q;    // serial operand, consumed MSB first
  logic [WIDTH-1:0] exp_q;    // exponent, consumed MSB first
  logic [CntW-1:0]  cnt_q;    // bit position within one product
  logic [CntW-1:0]  ecnt_q;   // exponent bit position

  logic             item_accept;
  logic             mod_small;
  logic             bit_last;
  logic             exp_last;
  logic [ExtW-1:0]  addend;
  logic [ExtW-1:0]  sum_ext;
  logic [ExtW-1:0]  mod_ext;
  logic [ExtW-1:0]  mod2_ext;
  logic [ExtW-1:0]  diff1;
  logic [ExtW-1:0]  diff2;
  logic [WIDTH-1:0] step;

  assign item_accept = start_i && !busy_o;
  assign mod_small   = (modulus_q[WIDTH-1:1] == '0);
  assign bit_last    = (cnt_q == CntLast);
  assign exp_last    = (ecnt_q == CntLast);
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WIDTH'(2);
      pub_exp_q  <= WIDTH'(1);
      priv_exp_q <= WIDTH'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MODULUS) begin
        modulus_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_PUBLIC_EXP) begin
        pub_exp_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_PRIVATE_EXP) begin
        priv_exp_q <= cfg_data_i;
      end
    end
  end

  // One shift-and-add step: (2 * prod + addend) mod n, with the sum below 3n.
  // During base reduction the addend is the next base bit; otherwise it is the
  // running power when the current multiplier bit is set.
  always_comb begin
    if (state_q == ST_REDUCE) begin
      addend = ExtW'(opb_q[WIDTH-1]);
    end else if (opb_q[WIDTH-1]) begin
      addend = {2'b00, acc_q};
    end else begin
      addend = '0;
    end
    sum_ext  = {1'b0, prod_q, 1'b0} + addend;
    mod_ext  = {2'b00, modulus_q};
    mod2_ext = {1'b0, modulus_q, 1'b0};
    diff1    = sum_ext - mod_ext;
    diff2    = sum_ext - mod2_ext;
    if (sum_ext >= mod2_ext) begin
      step = diff2[WIDTH-1:0];
    end else if (sum_ext >= mod_ext) begin
      step = diff1[WIDTH-1:0];
    end else begin
      step = sum_ext[WIDTH-1:0];
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d = state_q;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = mod_small ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (bit_last) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (bit_last) begin
          if (exp_q[WIDTH-1]) begin
            state_d = ST_MULT;
          end else if (exp_last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MULT: begin
        if (bit_last) begin
          state_d = exp_last ? ST_DONE : ST_SQUARE;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign power_result_o = acc_q;

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (item_accept) begin
          opb_q  <= base_value_i;
          exp_q  <= mode_i ? priv_exp_q : pub_exp_q;
          prod_q <= '0;
          acc_q  <= '0;
          cnt_q  <= '0;
          ecnt_q <= '0;
        end
      end
      ST_REDUCE: begin
        if (bit_last) begin
          cnt_q  <= '0;
          base_q <= step;
          acc_q  <= WIDTH'(1);
          opb_q  <= WIDTH'(1);
          prod_q <= '0;
        end else begin
          cnt_q  <= cnt_q + CntW'(1);
          prod_q <= step;
          opb_q  <= {opb_q[WIDTH-2:0], 1'b0};
        end
      end
      ST_SQUARE: begin
        if (bit_last) begin
          cnt_q  <= '0;
          acc_q  <= step;
          prod_q <= '0;
          if (exp_q[WIDTH-1]) begin
            opb_q <= base_q;
          end else begin
            opb_q  <= step;
            exp_q  <= {exp_q[WIDTH-2:0], 1'b0};
            ecnt_q <= ecnt_q + CntW'(1);
          end
        end else begin
          cnt_q  <= cnt_q + CntW'(1);
          prod_q <= step;
          opb_q  <= {opb_q[WIDTH-2:0], 1'b0};
        end
      end
      ST_MULT: begin
        if (bit_last) begin
          cnt_q  <= '0;
          acc_q  <= step;
          prod_q <= '0;
          opb_q  <= step;
          exp_q  <= {exp_q[WIDTH-2:0], 1'b0};
          ecnt_q <= ecnt_q + CntW'(1);
        end else begin
          cnt_q  <= cnt_q + CntW'(1);
          prod_q <= step;
          opb_q  <= {opb_q[WIDTH-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        cnt_q <= '0;
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  // A result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A delivered power is always reduced below the modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !mod_small) |-> (power_result_o < modulus_q))
    else $error("result not reduced below the modulus");

  // An accepted item makes the core busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) item_accept |=> busy_o)
    else $error("accepted item did not start the sequencer");

  // The base reduction hands over to the first squaring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE && bit_last) |=> (state_q == ST_SQUARE))
    else $error("base reduction did not end in a squaring");

endmodule

// File: dv/tb.sv
// Testbench for the modular exponentiation core: directed and random items checked against a built-in predictor.
`timescale 1ns / 1ps

module tb;
  import modexp_pkg::*;

  localparam int unsigned W = 16;
  localparam int unsigned RANDOM_TARGET = 1000;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 600;

  // Mode codes and the index that no register answers to.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic         mode;
    logic [W-1:0] base;
    logic [W-1:0] power;
  } power_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               mode_i = 1'b0;
  logic [W-1:0]       base_value_i = '0;
  logic               done_o;
  logic [W-1:0]       power_result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [W-1:0]       cfg_data_i = '0;

  // Register copies that the predictor works from.
  logic [W-1:0] cur_modulus = W'(2);
  logic [W-1:0] cur_pub_exp = W'(1);
  logic [W-1:0] cur_priv_exp = W'(1);

  power_item_t pending_powers[$];
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  modular_exponentiation_core #(
    .WIDTH(W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .base_value_i  (base_value_i),
    .done_o        (done_o),
    .power_result_o(power_result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Base raised to the exponent that the mode selects, reduced modulo the modulus.
  function automatic logic [W-1:0] predict_power(input logic mode, input logic [W-1:0] base);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] base_red;
    logic [2*W-1:0] mod_ext;
    logic [W-1:0]   expo;
    expo = (mode == MODE_DECRYPT) ? cur_priv_exp : cur_pub_exp;
    if (cur_modulus < W'(2)) begin
      return '0;
    end
    mod_ext = {{W{1'b0}}, cur_modulus};
    base_red = {{W{1'b0}}, base} % mod_ext;
    acc = 1;
    for (int i = W - 1; i >= 0; i--) begin
      acc = (acc * acc) % mod_ext;
      if (expo[i]) begin
        acc = (acc * base_red) % mod_ext;
      end
    end
    return acc[W-1:0];
  endfunction

  // Exponent values weighted toward zero, all ones and short exponents.
  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return W'($urandom_range(1, 15));
      default: return W'($urandom);
    endcase
  endfunction

  // Offer one item and hold start until the core takes it.
  task automatic send_item(input logic mode, input logic [W-1:0] base);
    power_item_t item;
    start_i <= 1'b1;
    mode_i <= mode;
    base_value_i <= base;
    do @(posedge clk_i); while (busy_o);
    item.mode = mode;
    item.base = base;
    item.power = predict_power(mode, base);
    pending_powers.push_back(item);
    items_sent++;
  endtask

  task automatic idle_gap(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Items go out in bursts of random length with random gaps between them.
  task automatic send_with_gaps(input logic mode, input logic [W-1:0] base);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        idle_gap($urandom_range(300, 700));
      end else begin
        idle_gap($urandom_range(1, 40));
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(mode, base);
  endtask

  // Stop sending and wait until every result has come and the core is idle.
  task automatic wait_drained();
    if (start_i) begin
      start_i <= 1'b0;
    end
    while (pending_powers.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  // Write one register while the core is idle; the last write of a group lowers valid.
  task automatic cfg_write(input logic [CfgIdxW-1:0] index, input logic [W-1:0] data,
                           input bit last);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_MODULUS:     cur_modulus = data;
      CFG_PUBLIC_EXP:  cur_pub_exp = data;
      CFG_PRIVATE_EXP: cur_priv_exp = data;
      default: ;
    endcase
    if (last) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  task automatic set_registers(input logic [W-1:0] modulus, input logic [W-1:0] pub_exp,
                               input logic [W-1:0] priv_exp);
    cfg_write(CFG_MODULUS, modulus, 1'b0);
    cfg_write(CFG_PUBLIC_EXP, pub_exp, 1'b0);
    cfg_write(CFG_PRIVATE_EXP, priv_exp, 1'b1);
  endtask

  // Items against the register values that reset leaves.
  task automatic test_reset_values();
    send_item(MODE_ENCRYPT, '0);
    send_item(MODE_DECRYPT, '1);
    send_item(MODE_ENCRYPT, W'(3));
  endtask

  // Largest modulus and exponents, zero exponent, zero and all-ones bases.
  task automatic test_extreme_values();
    set_registers('1, '1, '0);
    send_item(MODE_ENCRYPT, '1);
    send_item(MODE_ENCRYPT, W'(16'hFFFE));
    send_item(MODE_ENCRYPT, '0);
    send_item(MODE_DECRYPT, W'(16'hFFFE));
    send_item(MODE_DECRYPT, '0);
    set_registers(W'(16'hFFFD), W'(16'hAAAA), W'(16'h5555));
    send_item(MODE_ENCRYPT, W'(16'h5555));
    send_item(MODE_DECRYPT, W'(16'hAAAA));
  endtask

  // Bases not below the modulus, an ignored register index, and moduli below two.
  task automatic test_small_modulus();
    set_registers(W'(7), W'(5), '1);
    send_item(MODE_ENCRYPT, '1);
    send_item(MODE_ENCRYPT, W'(7));
    send_item(MODE_DECRYPT, W'(8));
    cfg_write(CFG_UNUSED, '0, 1'b1);
    send_item(MODE_ENCRYPT, W'(12));
    set_registers(W'(1), W'(3), '0);
    send_item(MODE_ENCRYPT, W'(5));
    send_item(MODE_DECRYPT, W'(5));
    set_registers('0, '1, W'(2));
    send_item(MODE_ENCRYPT, '1);
    send_item(MODE_DECRYPT, W'(9));
  endtask

  // Encrypt random messages with a real key pair, then decrypt each ciphertext.
  task automatic rsa_round_trips(input logic [W-1:0] modulus, input logic [W-1:0] pub_exp,
                                 input logic [W-1:0] priv_exp, input int unsigned count);
    logic [W-1:0] message;
    logic [W-1:0] cipher;
    set_registers(modulus, pub_exp, priv_exp);
    for (int unsigned k = 0; k < count; k++) begin
      message = W'($urandom_range(0, modulus - 1));
      send_with_gaps(MODE_ENCRYPT, message);
      cipher = predict_power(MODE_ENCRYPT, message);
      send_with_gaps(MODE_DECRYPT, cipher);
    end
  endtask

  task automatic test_rsa_keys();
    rsa_round_trips(W'(3233), W'(17), W'(2753), 20);
    rsa_round_trips(W'(143), W'(7), W'(103), 20);
    rsa_round_trips(W'(55), W'(3), W'(27), 20);
  endtask

  // Phases of random items, each under a fresh random register setting.
  task automatic test_random_settings();
    logic [W-1:0] modulus;
    int unsigned  phase_items;
    while (items_sent < RANDOM_TARGET) begin
      case ($urandom_range(0, 9))
        0: modulus = W'($urandom_range(2, 31));
        1: modulus = '1;
        2: modulus = W'($urandom_range(0, 1));
        default: modulus = W'($urandom_range(2, 65535));
      endcase
      set_registers(modulus, pick_exponent(), pick_exponent());
      phase_items = $urandom_range(20, 80);
      for (int unsigned k = 0; k < phase_items; k++) begin
        // Now and then the sender holds off until the core has emptied.
        if (k == phase_items / 2 && $urandom_range(0, 2) == 0) begin
          wait_drained();
        end
        send_with_gaps(1'($urandom_range(0, 1)), W'($urandom));
      end
    end
  endtask

  // Each result is compared with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    power_item_t want;
    if (rst_ni && done_o) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: result %0d with no item pending", $time, power_result_o);
        errors++;
      end else begin
        want = pending_powers.pop_front();
        if (power_result_o !== want.power) begin
          $display("%0t: power_result for base %0d mode %0d: expected %0d, actual %0d",
                   $time, want.base, want.mode, want.power, power_result_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_extreme_values();
    test_small_modulus();
    test_rsa_keys();
    test_random_settings();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_powers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: modular_exponentiation_core.f
hw/rtl/modexp_pkg.sv
hw/rtl/modular_exponentiation_core.sv
dv/tb.sv
